// File: rtl/auto_gain_exposure_iris_step_macros.svh
// assertion shorthands for the auto exposure / gain / iris step
// expects clk and rst_n in the scope of the module that uses them
`ifndef AUTO_GAIN_EXPOSURE_IRIS_STEP_MACROS_SVH
`define AUTO_GAIN_EXPOSURE_IRIS_STEP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define AGEI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AGEI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/agei_pkg.sv
// types, constants and helpers for the auto exposure / gain / iris step
// no dependencies
`timescale 1ns / 1ps

package agei_pkg;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_REF,
        REG_EXP_LIM,
        REG_EXP_GRAN,
        REG_GAIN_LIM,
        REG_GAIN_DB,
        REG_IRIS_LIM
    } reg_idx_t;

    typedef enum logic [1:0] {
        ADJ_NONE,
        ADJ_GAIN,
        ADJ_IRIS,
        ADJ_EXP
    } adj_t;

    // mode flag bit positions
    localparam int MODE_EXP  = 0;
    localparam int MODE_GAIN = 1;
    localparam int MODE_IRIS = 2;
    localparam int MODE_DB   = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // register reset values
    localparam logic [3:0]  RST_MODE = 4'd0;
    localparam logic [15:0] RST_REF  = 16'd32768;
    localparam logic [23:0] RST_GRAN = 24'd1;
    localparam logic [15:0] RST_DBM  = 16'd1541;

    // brightness floor (0.004 in Q0.16) and dead band in Q8.16
    localparam logic [15:0] B_MIN     = 16'd262;
    localparam logic [23:0] ONE_Q16   = 24'd65536;
    localparam logic [23:0] DB_LO     = 24'd62915;
    localparam logic [23:0] DB_HI     = 24'd68157;
    localparam logic [24:0] TWO_Q16   = 25'd131072;
    localparam logic [24:0] THREE_Q16 = 25'd196608;

    // floor(x/3) = (x * DIV3_MAGIC) >> 27, exact below 2^27
    localparam logic [25:0] DIV3_MAGIC   = 26'd44739243;
    localparam int          DIV3_SHIFT   = 27;
    // floor(x/100) = (x * DIV100_MAGIC) >> 38, exact below 2^32
    localparam logic [31:0] DIV100_MAGIC = 32'd2748779070;
    localparam int          DIV100_SHIFT = 38;
    localparam logic [6:0]  CREEP_NUM    = 7'd105;
    localparam logic [23:0] GAIN_ONE     = 24'd256;

    // pipeline map
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = 8;
    localparam int ST_DIV0    = 1;
    localparam int ST_D3M     = ST_DIV0 + DIV_STAGES;
    localparam int ST_D3      = ST_D3M + 1;
    localparam int ST_NORM    = ST_D3 + 1;
    localparam int SQ_STEPS   = 16;
    localparam int ST_SQ0     = ST_NORM + 1;
    localparam int ST_LMUL    = ST_SQ0 + SQ_STEPS;
    localparam int ST_DB      = ST_LMUL + 1;
    localparam int ST_FIN     = ST_DB + 1;
    localparam int NSTG       = ST_FIN + 1;

    typedef struct packed {
        logic [3:0]  mode;
        logic [15:0] ref_b;
        logic [23:0] emin;
        logic [23:0] emax;
        logic [23:0] gran;
        logic [23:0] gmin;
        logic [23:0] gmax;
        logic [15:0] dbm;
        logic [15:0] imin;
        logic [15:0] imax;
    } cfg_t;

    typedef struct packed {
        logic [23:0] new_exposure;
        logic [23:0] new_gain;
        logic [15:0] new_iris;
        adj_t        adjusted;
    } res_t;

    function automatic logic [31:0] clip_u(input logic [31:0] x, input logic [31:0] lo,
                                           input logic [31:0] hi);
        logic [31:0] y;
        y = (x > hi) ? hi : x;
        y = (y < lo) ? lo : y;
        return y;
    endfunction

endpackage

// File: rtl/agei_in_if.sv
// measurement channel: brightness and present settings, valid/ready
// no dependencies
`timescale 1ns / 1ps

interface agei_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] brightness;
    logic [23:0] current_exposure;
    logic [23:0] current_gain;
    logic [15:0] current_iris;

    modport source (output valid, brightness, current_exposure, current_gain, current_iris,
                    input ready);
    modport sink   (input valid, brightness, current_exposure, current_gain, current_iris,
                    output ready);
endinterface

// File: rtl/agei_out_if.sv
// update channel: new settings and which one changed, valid/ready
// no dependencies
`timescale 1ns / 1ps

interface agei_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] new_exposure;
    logic [23:0] new_gain;
    logic [15:0] new_iris;
    logic [1:0]  adjusted;

    modport source (output valid, new_exposure, new_gain, new_iris, adjusted, input ready);
    modport sink   (input valid, new_exposure, new_gain, new_iris, adjusted, output ready);
endinterface

// File: rtl/agei_core.sv
// pipelined datapath: ratio divider, damping, log2, candidates and decision
// depends on agei_pkg, agei_in_if, agei_out_if and the assertion macro header
`timescale 1ns / 1ps
`include "auto_gain_exposure_iris_step_macros.svh"

module agei_core (
    input  logic          clk,
    input  logic          rst_n,
    input  agei_pkg::cfg_t cfg,
    agei_in_if.sink       meas,
    agei_out_if.source    update
);
    import agei_pkg::*;

    typedef struct packed {
        logic [15:0] bm;
        logic [23:0] ce;
        logic [23:0] cg;
        logic [15:0] ci;
        logic [23:0] e;
        logic [23:0] g;
        logic [23:0] oe;
        logic [23:0] og;
        logic [15:0] oi;
        logic [31:0] dq;
        logic [15:0] rem;
        logic [23:0] r;
        logic [50:0] p3;
        logic [22:0] d3;
        logic [22:0] d4;
        logic [22:0] q;
        logic [4:0]  lp;
        logic [16:0] m;
        logic [15:0] frac;
        logic [46:0] pe;
        logic [46:0] pg;
        logic [38:0] pi;
        logic [30:0] ce105;
        logic [22:0] ci105;
        logic [62:0] pce;
        logic [54:0] pci;
        logic [23:0] tx;
        logic [23:0] tgm;
        logic [23:0] cre;
        logic [15:0] ti;
        logic [15:0] cri;
        logic [38:0] lm;
        logic [23:0] tg;
        adj_t        adj;
    } item_t;

    localparam int LAST = NSTG - 1;

    function automatic item_t stage_op(input int k, input item_t it, input cfg_t c);
        item_t              o;
        logic [16:0]        t;
        logic [24:0]        x3;
        logic [22:0]        x;
        logic [38:0]        xw;
        logic [4:0]         p;
        logic [33:0]        sq;
        logic [17:0]        s18;
        logic [23:0]        g0;
        logic [15:0]        i0;
        logic [30:0]        raw_e;
        logic [30:0]        diff;
        logic [5:0]         lsh;
        logic signed [21:0] ls;
        logic signed [16:0] ds;
        logic signed [38:0] ps;
        logic signed [38:0] lma;
        logic signed [22:0] delta;
        logic signed [25:0] sum;
        logic signed [25:0] gmin_s;
        logic signed [25:0] gmax_s;
        logic               ea;
        logic               ga;
        logic               ia;
        logic               outb;
        logic               act;
        int                 j;
        o  = it;
        ea = c.mode[MODE_EXP];
        ga = c.mode[MODE_GAIN];
        ia = c.mode[MODE_IRIS];
        j  = k - ST_SQ0;

        // restoring divider, a few quotient bits per stage
        if (k >= ST_DIV0 && k < ST_DIV0 + DIV_STAGES) begin
            for (int i = 0; i < DIV_STEP; i++) begin
                t = {o.rem, o.dq[31]};
                if (t >= {1'b0, o.bm}) begin
                    o.rem = 16'(t - {1'b0, o.bm});
                    o.dq  = {o.dq[30:0], 1'b1};
                end else begin
                    o.rem = t[15:0];
                    o.dq  = {o.dq[30:0], 1'b0};
                end
            end
        end

        if (k == ST_D3M) begin
            o.r  = it.dq[23:0];
            x3   = {1'b0, it.dq[23:0]} + TWO_Q16;
            o.p3 = 51'(x3) * 51'(DIV3_MAGIC);
            o.d4 = 23'(({1'b0, it.dq[23:0]} + THREE_Q16) >> 2);
        end

        if (k == ST_D3) begin
            o.d3 = 23'(it.p3 >> DIV3_SHIFT);
            o.q  = (it.r >= ONE_Q16) ? 23'(it.p3 >> DIV3_SHIFT) : it.r[22:0];
        end

        if (k == ST_NORM) begin
            // log2 normalize: leading one, mantissa into Q1.16
            x = (it.q == '0) ? 23'd1 : it.q;
            p = '0;
            for (int i = 0; i < 23; i++) begin
                if (x[i]) p = 5'(i);
            end
            xw     = {x, 16'd0};
            o.m    = 17'(xw >> p);
            o.lp   = p;
            o.frac = '0;
            // candidate products
            g0      = (it.g == '0) ? GAIN_ONE : it.g;
            i0      = (it.ci == '0) ? 16'd1 : it.ci;
            o.pe    = 47'(it.e) * 47'(it.d3);
            o.pg    = 47'(g0) * 47'(it.q);
            o.pi    = 39'(i0) * 39'(it.d4);
            o.ce105 = 31'(it.e) * 31'(CREEP_NUM);
            o.ci105 = 23'(it.ci) * 23'(CREEP_NUM);
        end

        // one fraction bit of the log per stage by squaring
        if (k >= ST_SQ0 && k < ST_SQ0 + SQ_STEPS) begin
            sq  = 34'(it.m) * 34'(it.m);
            s18 = sq[33:16];
            if (s18[17]) begin
                o.m = s18[17:1];
                o.frac[4'(SQ_STEPS - 1 - j)] = 1'b1;
            end else begin
                o.m = s18[16:0];
            end
        end

        if (k == ST_SQ0) begin
            o.pce = 63'(it.ce105) * 63'(DIV100_MAGIC);
            o.pci = 55'(it.ci105) * 55'(DIV100_MAGIC);
        end

        if (k == ST_SQ0 + 1) begin
            raw_e = it.pe[46:16];
            diff  = (raw_e > 31'(it.ce)) ? raw_e - 31'(it.ce) : 31'(it.ce) - raw_e;
            // exposure moves under half a sensor step are held
            o.tx  = (diff < 31'(c.gran >> 1)) ? it.ce
                  : 24'(clip_u(32'(raw_e), 32'(c.emin), 32'(c.emax)));
            o.ti  = 16'(clip_u(32'(it.pi[38:16]), 32'(c.imin), 32'(c.imax)));
            o.tgm = 24'(clip_u(32'(it.pg[46:16]), 32'(c.gmin), 32'(c.gmax)));
            o.cre = 24'(clip_u(32'(it.pce[62:DIV100_SHIFT]), 32'(c.emin), 32'(c.emax)));
            o.cri = 16'(clip_u(32'(it.pci[54:DIV100_SHIFT]), 32'(c.imin), 32'(c.imax)));
        end

        if (k == ST_LMUL) begin
            lsh  = {1'b0, it.lp} - 6'd16;
            ls   = {lsh, it.frac};
            ds   = {1'b0, c.dbm};
            ps   = ls * ds;
            o.lm = ps;
        end

        if (k == ST_DB) begin
            // divide by 2^16 rounding toward zero
            lma    = $signed(it.lm) + (it.lm[38] ? 39'sd65535 : 39'sd0);
            delta  = lma[38:16];
            sum    = $signed({2'b00, it.g}) + 26'(delta);
            gmin_s = $signed({2'b00, c.gmin});
            gmax_s = $signed({2'b00, c.gmax});
            if (sum > gmax_s) sum = gmax_s;
            if (sum < gmin_s) sum = gmin_s;
            o.tg = c.mode[MODE_DB] ? sum[23:0] : it.tgm;
        end

        if (k == ST_FIN) begin
            outb = (it.r < DB_LO) || (it.r > DB_HI);
            act  = 1'b0;
            if (outb) begin
                act = 1'b1;
                if (ga && it.tg < it.g) begin
                    o.og = it.tg; o.adj = ADJ_GAIN;
                end else if (ia && it.ti < it.ci) begin
                    o.oi = it.ti; o.adj = ADJ_IRIS;
                end else if (ea && it.tx != it.e) begin
                    o.oe = it.tx; o.adj = ADJ_EXP;
                end else if (ia && it.ti != it.ci) begin
                    o.oi = it.ti; o.adj = ADJ_IRIS;
                end else if (ga && it.tg != it.g) begin
                    o.og = it.tg; o.adj = ADJ_GAIN;
                end else begin
                    act = 1'b0;
                end
            end
            // slow creep toward less gain or less iris
            if (!act) begin
                if (ea && ga && it.g > c.gmin && it.e < c.emax) begin
                    o.oe = it.cre; o.adj = ADJ_EXP;
                end else if (ea && ia && it.ci > c.imin && it.e < c.emax) begin
                    o.oe = it.cre; o.adj = ADJ_EXP;
                end else if (ga && ia && it.g > c.gmin && it.ci < c.imax) begin
                    o.oi = it.cri; o.adj = ADJ_IRIS;
                end else begin
                    o.adj = ADJ_NONE;
                end
            end
        end
        return o;
    endfunction

    item_t            stg_reg [NSTG];
    item_t            stg_next [NSTG];
    logic [NSTG-1:0]  v_reg;
    res_t             out_reg;
    res_t             out_next;
    logic             out_v_reg;
    logic             out_load;
    logic             en;

    assign out_load   = !out_v_reg || update.ready;
    assign en         = !v_reg[LAST] || out_load;
    assign meas.ready = en;

    always_comb
    begin
        stg_next[0]     = '0;
        stg_next[0].bm  = (meas.brightness < B_MIN) ? B_MIN : meas.brightness;
        stg_next[0].ce  = meas.current_exposure;
        stg_next[0].cg  = meas.current_gain;
        stg_next[0].ci  = meas.current_iris;
        stg_next[0].e   = cfg.mode[MODE_EXP]
                        ? 24'(clip_u(32'(meas.current_exposure), 32'(cfg.emin), 32'(cfg.emax)))
                        : meas.current_exposure;
        stg_next[0].g   = cfg.mode[MODE_GAIN]
                        ? 24'(clip_u(32'(meas.current_gain), 32'(cfg.gmin), 32'(cfg.gmax)))
                        : meas.current_gain;
        stg_next[0].oe  = stg_next[0].e;
        stg_next[0].og  = stg_next[0].g;
        stg_next[0].oi  = cfg.mode[MODE_IRIS]
                        ? 16'(clip_u(32'(meas.current_iris), 32'(cfg.imin), 32'(cfg.imax)))
                        : meas.current_iris;
        stg_next[0].dq  = {cfg.ref_b, 16'd0};
        stg_next[0].adj = ADJ_NONE;
        for (int k = 1; k < NSTG; k++) begin
            stg_next[k] = stage_op(k, stg_reg[k-1], cfg);
        end
    end

    always_comb
    begin
        out_next.new_exposure = stg_reg[LAST].oe;
        out_next.new_gain     = stg_reg[LAST].og;
        out_next.new_iris     = stg_reg[LAST].oi;
        out_next.adjusted     = stg_reg[LAST].adj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v_reg <= {v_reg[NSTG-2:0], meas.valid};
            end
            if (out_load)
            begin
                out_v_reg <= v_reg[LAST];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NSTG; k++) begin
                stg_reg[k] <= stg_next[k];
            end
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign update.valid        = out_v_reg;
    assign update.new_exposure = out_reg.new_exposure;
    assign update.new_gain     = out_reg.new_gain;
    assign update.new_iris     = out_reg.new_iris;
    assign update.adjusted     = out_reg.adjusted;

    `AGEI_ASSERT_NOW(a_div_rem, v_reg[ST_D3M-1], stg_reg[ST_D3M-1].rem < stg_reg[ST_D3M-1].bm, "divider remainder not below divisor")
    `AGEI_ASSERT_NOW(a_log_norm, v_reg[ST_NORM], stg_reg[ST_NORM].m[16], "log mantissa not normalized")
    `AGEI_ASSERT_NEXT(a_stall_hold, v_reg[0] && !en, v_reg[0], "first stage lost an item under stall")
    `AGEI_ASSERT_NOW(a_gain_mode, out_v_reg && out_reg.adjusted == ADJ_GAIN, cfg.mode[MODE_GAIN], "gain changed while not in auto")
    `AGEI_ASSERT_NOW(a_exp_mode, out_v_reg && out_reg.adjusted == ADJ_EXP, cfg.mode[MODE_EXP], "exposure changed while not in auto")

endmodule

// File: rtl/auto_gain_exposure_iris_step.sv
// channel   | dir | payload
// meas      | in  | brightness, current_exposure, current_gain, current_iris
// update    | out | new_exposure, new_gain, new_iris, adjusted
// cfg write | in  | cfg_we, cfg_idx, cfg_wdata
//
// one item per cycle sustained while update accepts (ready high)
// the 31-stage datapath (8 divider stages, 16 log squaring stages) sets the latency
// an output register decouples the sides: a stalled update still lets bubbles fill
// reset clears all valid bits and loads the register defaults
// depends on agei_pkg, agei_in_if, agei_out_if, agei_core
`timescale 1ns / 1ps

module auto_gain_exposure_iris_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [agei_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [agei_pkg::CFG_DATA_W-1:0] cfg_wdata,
    agei_in_if.sink                         meas,
    agei_out_if.source                      update
);
    import agei_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode  <= RST_MODE;
            cfg_reg.ref_b <= RST_REF;
            cfg_reg.emin  <= '0;
            cfg_reg.emax  <= '0;
            cfg_reg.gran  <= RST_GRAN;
            cfg_reg.gmin  <= '0;
            cfg_reg.gmax  <= '0;
            cfg_reg.dbm   <= RST_DBM;
            cfg_reg.imin  <= '0;
            cfg_reg.imax  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_idx))
                REG_MODE:     cfg_reg.mode  <= cfg_wdata[3:0];
                REG_REF:      cfg_reg.ref_b <= cfg_wdata[15:0];
                REG_EXP_LIM:
                begin
                    cfg_reg.emin <= cfg_wdata[23:0];
                    cfg_reg.emax <= cfg_wdata[47:24];
                end
                REG_EXP_GRAN: cfg_reg.gran  <= cfg_wdata[23:0];
                REG_GAIN_LIM:
                begin
                    cfg_reg.gmin <= cfg_wdata[23:0];
                    cfg_reg.gmax <= cfg_wdata[47:24];
                end
                REG_GAIN_DB:  cfg_reg.dbm   <= cfg_wdata[15:0];
                REG_IRIS_LIM:
                begin
                    cfg_reg.imin <= cfg_wdata[15:0];
                    cfg_reg.imax <= cfg_wdata[31:16];
                end
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    agei_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .meas   (meas),
        .update (update)
    );

endmodule
